[rtl/skr_pkg.sv]
// Shared types and constants for the sorted key registry.
package skr_pkg;

    // Default number of entries in the table.
    localparam int CAPACITY_DEF = 256;

    // Field widths.
    localparam int CMD_W    = 2;
    localparam int TYPE_W   = 16;
    localparam int QUAL_W   = 16;
    localparam int IDENT_W  = 32;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 2;
    localparam int KEY_W    = TYPE_W + QUAL_W + IDENT_W;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GET   = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

    // One request.
    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [TYPE_W-1:0]   res_type;
        logic [QUAL_W-1:0]   qualifier;
        logic [IDENT_W-1:0]  ident;
        logic [HANDLE_W-1:0] handle;
    } req_t;

    // One response.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] found_handle;
    } rsp_t;

    // Controls broadcast from the sequencer to every cell.
    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic clr_en;
    } cell_ctrl_t;

endpackage

[rtl/skr_cell.sv]
// One table slot of the sorted key registry: stored entry, compare flags and shift logic.
module skr_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  skr_pkg::cell_ctrl_t           ctrl,
    input  logic [skr_pkg::KEY_W-1:0]     new_key,
    input  logic [skr_pkg::HANDLE_W-1:0]  new_handle,
    input  logic [skr_pkg::KEY_W-1:0]     left_key,
    input  logic [skr_pkg::HANDLE_W-1:0]  left_handle,
    input  logic                          left_valid,
    input  logic                          left_lt,
    output logic [skr_pkg::KEY_W-1:0]     key,
    output logic [skr_pkg::HANDLE_W-1:0]  handle,
    output logic                          valid,
    output logic                          lt,
    output logic                          eq
);
    import skr_pkg::*;

    logic [KEY_W-1:0]    key_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic                valid_reg;
    logic                lt_reg;
    logic                eq_reg;

    // Occupancy and compare flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else if (ctrl.clr_en)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            if (ctrl.cmp_en)
            begin
                lt_reg <= valid_reg && (key_reg < new_key);
                eq_reg <= valid_reg && (key_reg == new_key);
            end
            // A slot becomes occupied when the occupied run grows into it.
            if (ctrl.ins_en)
            begin
                valid_reg <= valid_reg | left_valid;
            end
        end
    end

    // Entry data: keep if smaller than the new key, take the new entry at the
    // insertion point, otherwise shift in from the left.
    always_ff @(posedge clk)
    begin
        if (ctrl.ins_en && !lt_reg)
        begin
            if (left_lt)
            begin
                key_reg    <= new_key;
                handle_reg <= new_handle;
            end
            else if (left_valid)
            begin
                key_reg    <= left_key;
                handle_reg <= left_handle;
            end
        end
    end

    assign key    = key_reg;
    assign handle = handle_reg;
    assign valid  = valid_reg;
    assign lt     = lt_reg;
    assign eq     = eq_reg;

endmodule

[rtl/sorted_key_registry.sv]
// Top level of the sorted key registry: request sequencer and row of cells.
//
//   channel   signals                       direction   payload
//   request   req_valid, req_stall, req     in          skr_pkg::req_t
//   response  rsp_valid, rsp_stall, rsp     out         skr_pkg::rsp_t
//
// Each request goes through a compare state and then a resolve state: all cells
// compare against the key in the first, and the match is resolved, the
// shift-insert done and the response registered in the second. A new request
// can be taken while the last one resolves. Reset empties the table at once.
// A stalled response holds the sequencer in its resolve cycle.
module sorted_key_registry #(
    parameter int CAPACITY = skr_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  skr_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output skr_pkg::rsp_t rsp
);
    import skr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_RES
    } state_t;

    state_t      state_reg;
    logic        rsp_valid_reg;
    req_t        req_reg;
    rsp_t        rsp_reg;
    rsp_t        rsp_next;
    cell_ctrl_t  ctrl;
    logic        out_free;
    logic        resolve;
    logic        accept;
    logic        dup;
    logic        full;
    logic [KEY_W-1:0]    new_key;
    logic [HANDLE_W-1:0] hit_handle;

    logic [KEY_W-1:0]    cell_key    [CAPACITY];
    logic [HANDLE_W-1:0] cell_handle [CAPACITY];
    logic                cell_valid  [CAPACITY];
    logic                cell_lt     [CAPACITY];
    logic                cell_eq     [CAPACITY];

    // Handshake.
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign resolve   = (state_reg == S_RES) && out_free;
    assign req_stall = (state_reg == S_CMP) || ((state_reg == S_RES) && !out_free);
    assign accept    = req_valid && !req_stall;
    assign new_key   = {req_reg.res_type, req_reg.qualifier, req_reg.ident};

    // Match reduction over the row of cells.
    always_comb
    begin
        dup        = 1'b0;
        hit_handle = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            dup        = dup | cell_eq[i];
            hit_handle = hit_handle | ({HANDLE_W{cell_eq[i]}} & cell_handle[i]);
        end
    end

    assign full = cell_valid[CAPACITY-1];

    // Cell controls for the current cycle.
    always_comb
    begin
        ctrl.cmp_en = (state_reg == S_CMP);
        ctrl.clr_en = resolve && (req_reg.command == CMD_CLEAR);
        ctrl.ins_en = resolve && (req_reg.command == CMD_ADD) && !dup && !full;
    end

    // Response for the request being resolved.
    always_comb
    begin
        rsp_next.status       = ST_OK;
        rsp_next.found_handle = '0;
        case (req_reg.command)
            CMD_ADD:
            begin
                if (dup)
                begin
                    rsp_next.status = ST_DUP;
                end
                else if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            CMD_GET:
            begin
                if (dup)
                begin
                    rsp_next.found_handle = hit_handle;
                end
                else
                begin
                    rsp_next.status = ST_MISS;
                end
            end
            default:
            begin
                rsp_next.status = ST_OK;
            end
        endcase
    end

    // Sequencer state and registered response.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    state_reg <= S_RES;
                end
                S_RES:
                begin
                    if (out_free)
                    begin
                        state_reg <= accept ? S_CMP : S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (resolve)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_reg       <= rsp_next;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Request payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Row of cells; the first cell sees an always-smaller, always-occupied left.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            skr_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_key     (new_key),
                .new_handle  (req_reg.handle),
                .left_key    (new_key),
                .left_handle (req_reg.handle),
                .left_valid  (1'b1),
                .left_lt     (1'b1),
                .key         (cell_key[i]),
                .handle      (cell_handle[i]),
                .valid       (cell_valid[i]),
                .lt          (cell_lt[i]),
                .eq          (cell_eq[i])
            );
        end
        else
        begin : g_rest
            skr_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_key     (new_key),
                .new_handle  (req_reg.handle),
                .left_key    (cell_key[i-1]),
                .left_handle (cell_handle[i-1]),
                .left_valid  (cell_valid[i-1]),
                .left_lt     (cell_lt[i-1]),
                .key         (cell_key[i]),
                .handle      (cell_handle[i]),
                .valid       (cell_valid[i]),
                .lt          (cell_lt[i]),
                .eq          (cell_eq[i])
            );
        end
    end

endmodule
